// ----- rtl/asam_pkg.sv -----
// shared types, constants and codes for the adaptive spectral angle masker
// no dependencies; the top, datapath, controller and testbench files refer to it by scoped names
package asam_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ADAPT_SHIFT  = 8;
    localparam int ADAPT_W      = SAMPLE_W + ADAPT_SHIFT;
    localparam int COS_FRAC     = 16;
    localparam int MASK_W       = 8;
    localparam int BAND_FIELD_W = 6;
    localparam int REF_FIELD_W  = 3;
    localparam int COUNT_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_BANDS = 64;
    localparam int DEF_REFS  = 8;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_BAND_USED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD  = 3'd3;

    localparam logic [3:0]              RST_REF_COUNT      = 4'd1;
    localparam logic [BAND_FIELD_W-1:0] RST_FIRST_BAND     = 6'd0;
    localparam logic [BAND_FIELD_W-1:0] RST_LAST_BAND_USED = 6'd63;
    localparam logic [15:0]             RST_COS_THRESHOLD  = 16'd62609;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [SAMPLE_W-1:0]     sample_value;
        logic [REF_FIELD_W-1:0]  ref_index;
        logic [BAND_FIELD_W-1:0] band_index;
        logic                    last_band;
        logic                    last_in_line;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] belongs_mask;
        logic              belongs_any;
        logic              line_end;
    } out_item_t;

    typedef struct packed {
        logic [3:0]              ref_count;
        logic [BAND_FIELD_W-1:0] first_band;
        logic [BAND_FIELD_W-1:0] last_band_used;
        logic [15:0]             cos_threshold;
    } cfg_t;

    typedef enum logic [1:0] {
        SQ_P,
        SQ_F,
        SQ_A
    } sq_sel_t;

    typedef struct packed {
        logic    accept_en;
        logic    acc_clr;
        logic    rd;
        logic    acc;
        logic    sq_start;
        logic    sq_cap;
        sq_sel_t sq_sel;
        logic    den_load;
        logic    copy;
        logic    div_cos;
        logic    hit_set;
        logic    hit_q;
        logic    mark;
        logic    upd_load;
        logic    upd_write;
        logic    cnt_write;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic pipe_busy;
        logic sq_done;
        logic den_zero;
        logic dot_big;
        logic div_done;
        logic hit;
        logic out_full;
    } stat_t;

endpackage

// ----- rtl/adaptive_spectral_angle_masker.sv -----
// adaptive spectral angle masker: hyperspectral pixel classification by
// spectral angle against fixed and running-mean references
//
// item channel (item_valid/item_ready/item): one beat per band sample, or one
// beat per reference band load. loads and non-final samples are accepted
// back to back while the block is idle.
// a sample beat with last_band closes the pixel; the block then stops taking
// beats while it classifies. per active reference: a product sweep over the
// bands, a drain of the multiply stage, 3 roots on the shared root unit and
// up to 2 cosine divides on the shared divider. a matching reference adds an
// update pass over each band (read, load, 24-step running-mean divide).
// result channel (result_valid/result_ready/result): one beat per pixel,
// held in an output register; if the receiver stalls, the block finishes
// the next pixel's sample beats and waits only before writing a new result.
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while idle.
// reset (rst_n low, asynchronous) restores register defaults, zeroes the
// band counter and match counts; reference memories hold nothing useful
// until loaded.
// uses asam_pkg, asam_ctrl and asam_datapath
module adaptive_spectral_angle_masker #(
    parameter int BANDS = asam_pkg::DEF_BANDS,
    parameter int REFS  = asam_pkg::DEF_REFS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  asam_pkg::in_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output asam_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asam_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int BW = $clog2(BANDS);
    localparam int KW = (REFS > 1) ? $clog2(REFS) : 1;

    asam_pkg::cfg_t  cfg_reg;
    asam_pkg::cmd_t  cmd;
    asam_pkg::stat_t stat;
    logic [BW-1:0]   band;
    logic [KW-1:0]   ref_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_count      <= asam_pkg::RST_REF_COUNT;
            cfg_reg.first_band     <= asam_pkg::RST_FIRST_BAND;
            cfg_reg.last_band_used <= asam_pkg::RST_LAST_BAND_USED;
            cfg_reg.cos_threshold  <= asam_pkg::RST_COS_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                asam_pkg::CFG_REF_COUNT:      cfg_reg.ref_count      <= cfg_data[3:0];
                asam_pkg::CFG_FIRST_BAND:     cfg_reg.first_band     <= cfg_data[5:0];
                asam_pkg::CFG_LAST_BAND_USED: cfg_reg.last_band_used <= cfg_data[5:0];
                asam_pkg::CFG_COS_THRESHOLD:  cfg_reg.cos_threshold  <= cfg_data;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    asam_ctrl #(.BANDS(BANDS), .REFS(REFS)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .stat    (stat),
        .cmd     (cmd),
        .band    (band),
        .ref_sel (ref_sel)
    );

    asam_datapath #(.BANDS(BANDS), .REFS(REFS)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .band         (band),
        .ref_sel      (ref_sel),
        .stat         (stat),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- rtl/asam_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module asam_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/asam_sqrt.sv -----
// iterative floor integer square root, two radicand bits per cycle
// no dependencies
module asam_sqrt #(
    parameter int W = 54
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   value,
    output logic           done,
    output logic [W/2-1:0] root
);

    localparam int STEPS = W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [W-1:0]  v_reg;
    logic [W-1:0]  res_reg;
    logic [W-1:0]  bit_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  trial;
    logic          ge;

    assign trial = res_reg + bit_reg;
    assign ge    = (v_reg >= trial);
    assign done  = done_reg;
    assign root  = res_reg[W/2-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// ----- rtl/asam_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// remainder starts below the divisor; dividend bits shift in msb first
// no dependencies
module asam_div #(
    parameter int DW = 49,
    parameter int QW = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            rem_init,
    input  logic [QW-1:0]            dividend,
    input  logic [DW-1:0]            divisor,
    input  logic [$clog2(QW+1)-1:0]  steps,
    output logic                     done,
    output logic [QW-1:0]            quot
);

    localparam int SC_W = $clog2(QW + 1);

    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [QW-1:0]   dd_reg;
    logic [QW-1:0]   q_reg;
    logic [SC_W-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     r_shift;
    logic            ge;

    assign r_shift = {r_reg, dd_reg[QW-1]};
    assign ge      = (r_shift >= {1'b0, d_reg});
    assign done    = done_reg;
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SC_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg  <= rem_init;
            d_reg  <= divisor;
            dd_reg <= dividend;
            q_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                r_reg <= DW'(r_shift - {1'b0, d_reg});
            end
            else
            begin
                r_reg <= r_shift[DW-1:0];
            end
            dd_reg <= dd_reg << 1;
            q_reg  <= {q_reg[QW-2:0], ge};
        end
    end

endmodule

// ----- rtl/asam_datapath.sv -----
// datapath: pixel and reference memories, product accumulators, root and
// divide units, match counts and the result register; uses asam_pkg,
// asam_ram, asam_sqrt and asam_div
module asam_datapath #(
    parameter int BANDS = asam_pkg::DEF_BANDS,
    parameter int REFS  = asam_pkg::DEF_REFS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  asam_pkg::cfg_t                        cfg,
    input  asam_pkg::cmd_t                        cmd,
    input  logic [$clog2(BANDS)-1:0]              band,
    input  logic [((REFS > 1) ? $clog2(REFS) : 1)-1:0] ref_sel,
    output asam_pkg::stat_t                       stat,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  asam_pkg::in_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output asam_pkg::out_item_t                   result
);

    localparam int SB     = asam_pkg::SAMPLE_W;
    localparam int AW     = asam_pkg::ADAPT_W;
    localparam int MW     = asam_pkg::MASK_W;
    localparam int BW     = $clog2(BANDS);
    localparam int KW     = (REFS > 1) ? $clog2(REFS) : 1;
    localparam int ADDR_W = $clog2(REFS * BANDS);
    localparam int PSQ_W  = 2 * SB + BW;
    localparam int ASQ_W  = 2 * AW + BW;
    localparam int DA_W   = SB + AW + BW;
    localparam int SQ_W   = ASQ_W + (ASQ_W % 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int DEN_W  = 2 * ROOT_W;
    localparam int DV_W   = (DEN_W > asam_pkg::COUNT_W) ? DEN_W : asam_pkg::COUNT_W;
    localparam int QW     = AW;
    localparam int SC_W   = $clog2(QW + 1);
    localparam int CNT_W  = asam_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic               accept;
    logic               load_ok;
    logic [ADDR_W-1:0]  load_addr;
    logic [ADDR_W-1:0]  ref_addr;
    logic [BW-1:0]      band_cnt_reg;

    logic [SB-1:0]      pix_rdata;
    logic [SB-1:0]      fix_rdata;
    logic [AW-1:0]      ada_rdata;
    logic               ada_we;
    logic [ADDR_W-1:0]  ada_waddr;
    logic [AW-1:0]      ada_wdata;

    logic               v1_reg;
    logic               v2_reg;
    logic [2*SB-1:0]    pp_reg;
    logic [2*SB-1:0]    ff_reg;
    logic [2*AW-1:0]    aa_reg;
    logic [2*SB-1:0]    pf_reg;
    logic [SB+AW-1:0]   pa_reg;
    logic [PSQ_W-1:0]   p_acc_reg;
    logic [PSQ_W-1:0]   f_acc_reg;
    logic [ASQ_W-1:0]   a_acc_reg;
    logic [PSQ_W-1:0]   df_acc_reg;
    logic [DA_W-1:0]    da_acc_reg;

    logic [SQ_W-1:0]    sq_value;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [ROOT_W-1:0]  np_reg;
    logic [ROOT_W-1:0]  nf_reg;
    logic [ROOT_W-1:0]  na_reg;
    logic [ROOT_W-1:0]  nq;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   dot_sel;

    logic               div_start;
    logic [DV_W-1:0]    div_rem;
    logic [QW-1:0]      div_dd;
    logic [DV_W-1:0]    div_dv;
    logic [SC_W-1:0]    div_steps;
    logic               div_done;
    logic [QW-1:0]      div_q;

    logic [AW-1:0]      target;
    logic [AW-1:0]      mag;
    logic               up_reg;
    logic [AW-1:0]      a_old_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   count_reg [REFS];

    logic                       hit_reg;
    logic [MW-1:0]              mask_reg;
    logic                       any_reg;
    logic                       eol_reg;
    logic                       out_valid_reg;
    asam_pkg::out_item_t        out_reg;

    assign item_ready = cmd.accept_en;
    assign accept     = item_valid & cmd.accept_en;
    assign load_ok    = (int'(item.ref_index) < REFS) && (int'(item.band_index) < BANDS);
    assign load_addr  = ADDR_W'(ADDR_W'(item.ref_index) * ADDR_W'(BANDS)
                        + ADDR_W'(item.band_index));
    assign ref_addr   = ADDR_W'(ADDR_W'(ref_sel) * ADDR_W'(BANDS) + ADDR_W'(band));

    // band position of the pixel being received
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_cnt_reg <= '0;
        end
        else if (accept && item.opcode == asam_pkg::OP_PIXEL)
        begin
            if (item.last_band || band_cnt_reg == BW'(BANDS - 1))
            begin
                band_cnt_reg <= '0;
            end
            else
            begin
                band_cnt_reg <= band_cnt_reg + 1'b1;
            end
        end
    end

    asam_ram #(.W(SB), .DEPTH(BANDS)) u_pix_ram (
        .clk   (clk),
        .we    (accept && item.opcode == asam_pkg::OP_PIXEL),
        .waddr (band_cnt_reg),
        .wdata (item.sample_value),
        .raddr (band),
        .rdata (pix_rdata)
    );

    asam_ram #(.W(SB), .DEPTH(REFS * BANDS)) u_fix_ram (
        .clk   (clk),
        .we    (accept && item.opcode == asam_pkg::OP_LOAD && load_ok),
        .waddr (load_addr),
        .wdata (item.sample_value),
        .raddr (ref_addr),
        .rdata (fix_rdata)
    );

    always_comb
    begin
        ada_we    = 1'b0;
        ada_waddr = ref_addr;
        ada_wdata = up_reg ? (a_old_reg + div_q) : (a_old_reg - div_q);
        if (accept && item.opcode == asam_pkg::OP_LOAD && load_ok)
        begin
            ada_we    = 1'b1;
            ada_waddr = load_addr;
            ada_wdata = {item.sample_value, {asam_pkg::ADAPT_SHIFT{1'b0}}};
        end
        else if (cmd.upd_write)
        begin
            ada_we = 1'b1;
        end
    end

    asam_ram #(.W(AW), .DEPTH(REFS * BANDS)) u_ada_ram (
        .clk   (clk),
        .we    (ada_we),
        .waddr (ada_waddr),
        .wdata (ada_wdata),
        .raddr (ref_addr),
        .rdata (ada_rdata)
    );

    // read -> multiply -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd & cmd.acc;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            pp_reg <= pix_rdata * pix_rdata;
            ff_reg <= fix_rdata * fix_rdata;
            aa_reg <= ada_rdata * ada_rdata;
            pf_reg <= pix_rdata * fix_rdata;
            pa_reg <= pix_rdata * ada_rdata;
        end
        if (cmd.acc_clr)
        begin
            p_acc_reg  <= '0;
            f_acc_reg  <= '0;
            a_acc_reg  <= '0;
            df_acc_reg <= '0;
            da_acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            p_acc_reg  <= p_acc_reg + PSQ_W'(pp_reg);
            f_acc_reg  <= f_acc_reg + PSQ_W'(ff_reg);
            a_acc_reg  <= a_acc_reg + ASQ_W'(aa_reg);
            df_acc_reg <= df_acc_reg + PSQ_W'(pf_reg);
            da_acc_reg <= da_acc_reg + DA_W'(pa_reg);
        end
    end

    always_comb
    begin
        case (cmd.sq_sel)
            asam_pkg::SQ_P: sq_value = SQ_W'(p_acc_reg);
            asam_pkg::SQ_F: sq_value = SQ_W'(f_acc_reg);
            asam_pkg::SQ_A: sq_value = SQ_W'(a_acc_reg);
            default:        sq_value = '0;
        endcase
    end

    asam_sqrt #(.W(SQ_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.sq_cap)
        begin
            case (cmd.sq_sel)
                asam_pkg::SQ_P: np_reg <= sq_root;
                asam_pkg::SQ_F: nf_reg <= sq_root;
                asam_pkg::SQ_A: na_reg <= sq_root;
                default:        np_reg <= sq_root;
            endcase
        end
        if (cmd.den_load)
        begin
            den_reg <= np_reg * nq;
        end
    end

    assign nq      = cmd.copy ? na_reg : nf_reg;
    assign dot_sel = cmd.copy ? DEN_W'(da_acc_reg) : DEN_W'(df_acc_reg);

    // cosine: remainder starts at the dot product, zeros shift in
    // running mean: remainder starts at zero, the magnitude shifts in
    assign target    = {pix_rdata, {asam_pkg::ADAPT_SHIFT{1'b0}}};
    assign mag       = (target >= ada_rdata) ? (target - ada_rdata) : (ada_rdata - target);
    assign div_start = cmd.div_cos | cmd.upd_load;
    assign div_rem   = cmd.div_cos ? DV_W'(dot_sel) : '0;
    assign div_dd    = cmd.div_cos ? '0 : mag;
    assign div_dv    = cmd.div_cos ? DV_W'(den_reg) : DV_W'(n_reg);
    assign div_steps = cmd.div_cos ? SC_W'(asam_pkg::COS_FRAC) : SC_W'(AW);

    asam_div #(.DW(DV_W), .QW(QW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dd),
        .divisor  (div_dv),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.upd_load)
        begin
            up_reg    <= (target >= ada_rdata);
            a_old_reg <= ada_rdata;
        end
        if (cmd.mark)
        begin
            n_reg <= (count_reg[ref_sel] == CNT_MAX) ? CNT_MAX : count_reg[ref_sel] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REFS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (accept && item.opcode == asam_pkg::OP_LOAD && load_ok)
        begin
            count_reg[KW'(item.ref_index)] <= '0;
        end
        else if (cmd.cnt_write)
        begin
            count_reg[ref_sel] <= n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            mask_reg      <= '0;
            any_reg       <= 1'b0;
            eol_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_clr)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.hit_set)
            begin
                hit_reg <= 1'b1;
            end
            else if (cmd.hit_q && div_q > QW'(cfg.cos_threshold))
            begin
                hit_reg <= 1'b1;
            end

            if (stat.start)
            begin
                mask_reg <= '0;
                any_reg  <= 1'b0;
                eol_reg  <= item.last_in_line;
            end
            else if (cmd.mark)
            begin
                // references past the mask width only count toward any-match
                mask_reg <= mask_reg | (MW'(1) << ref_sel);
                any_reg  <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.belongs_mask <= mask_reg;
            out_reg.belongs_any  <= any_reg;
            out_reg.line_end     <= eol_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign stat.start     = accept && item.opcode == asam_pkg::OP_PIXEL && item.last_band;
    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.sq_done   = sq_done;
    assign stat.den_zero  = (np_reg == '0) || (nq == '0);
    assign stat.dot_big   = (dot_sel >= den_reg);
    assign stat.div_done  = div_done;
    assign stat.hit       = hit_reg;
    assign stat.out_full  = out_valid_reg;

endmodule

// ----- rtl/asam_ctrl.sv -----
// controller: walks references and bands for one pixel and sequences the
// root, cosine and running-mean steps of the datapath; uses asam_pkg
module asam_ctrl #(
    parameter int BANDS = asam_pkg::DEF_BANDS,
    parameter int REFS  = asam_pkg::DEF_REFS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  asam_pkg::cfg_t                        cfg,
    input  asam_pkg::stat_t                       stat,
    output asam_pkg::cmd_t                        cmd,
    output logic [$clog2(BANDS)-1:0]              band,
    output logic [((REFS > 1) ? $clog2(REFS) : 1)-1:0] ref_sel
);

    localparam int BW      = $clog2(BANDS);
    localparam int KW      = (REFS > 1) ? $clog2(REFS) : 1;
    localparam int RANGE_W = ((BW > asam_pkg::BAND_FIELD_W) ? BW : asam_pkg::BAND_FIELD_W) + 1;
    localparam int NR_W    = ($clog2(REFS + 1) > 4) ? $clog2(REFS + 1) : 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REF,
        S_SWEEP,
        S_DRAIN,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DEN,
        S_CHK,
        S_DIV,
        S_DECIDE,
        S_UPD_RD,
        S_UPD_LD,
        S_UPD_DIV,
        S_NEXT,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [BW-1:0]     b_reg;
    logic [KW-1:0]     k_reg;
    asam_pkg::sq_sel_t sel_reg;
    logic              copy_reg;

    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi_raw;
    logic [RANGE_W-1:0] hi;
    logic [RANGE_W-1:0] top_band;
    logic               empty;
    logic [NR_W-1:0]    nref;
    logic               last_ref;
    logic               last_b;

    always_comb
    begin
        lo       = RANGE_W'(cfg.first_band);
        hi_raw   = RANGE_W'(cfg.last_band_used);
        top_band = RANGE_W'(BANDS - 1);
        hi       = (hi_raw > top_band) ? top_band : hi_raw;
        empty    = (lo > hi) || (lo > top_band);
        nref     = (NR_W'(cfg.ref_count) > NR_W'(REFS)) ? NR_W'(REFS) : NR_W'(cfg.ref_count);
        last_ref = (NR_W'(k_reg) + NR_W'(1) >= nref);
        last_b   = (RANGE_W'(b_reg) == hi);
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sq_sel = sel_reg;
        cmd.copy   = copy_reg;
        case (state_reg)
            S_IDLE:    cmd.accept_en = 1'b1;
            S_REF:     cmd.acc_clr   = 1'b1;
            S_SWEEP:
            begin
                cmd.rd  = 1'b1;
                cmd.acc = 1'b1;
            end
            S_SQ_GO:   cmd.sq_start  = 1'b1;
            S_SQ_WAIT: cmd.sq_cap    = stat.sq_done;
            S_DEN:     cmd.den_load  = 1'b1;
            S_CHK:
            begin
                cmd.hit_set = !stat.den_zero && stat.dot_big;
                cmd.div_cos = !stat.den_zero && !stat.dot_big;
            end
            S_DIV:     cmd.hit_q     = stat.div_done;
            S_DECIDE:  cmd.mark      = stat.hit;
            S_UPD_RD:  cmd.rd        = 1'b1;
            S_UPD_LD:  cmd.upd_load  = 1'b1;
            S_UPD_DIV:
            begin
                cmd.upd_write = stat.div_done;
                cmd.cnt_write = stat.div_done && last_b;
            end
            S_OUT:     cmd.out_load  = !stat.out_full;
            default:   cmd.accept_en = 1'b0;
        endcase
    end

    assign band    = b_reg;
    assign ref_sel = k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            b_reg     <= '0;
            k_reg     <= '0;
            sel_reg   <= asam_pkg::SQ_P;
            copy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (stat.start)
                    begin
                        k_reg <= '0;
                        if (empty || nref == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_REF;
                        end
                    end
                end
                S_REF:
                begin
                    b_reg     <= BW'(lo);
                    state_reg <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    if (last_b)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        b_reg <= b_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (!stat.pipe_busy)
                    begin
                        sel_reg   <= asam_pkg::SQ_P;
                        state_reg <= S_SQ_GO;
                    end
                end
                S_SQ_GO:
                begin
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (stat.sq_done)
                    begin
                        case (sel_reg)
                            asam_pkg::SQ_P:
                            begin
                                sel_reg   <= asam_pkg::SQ_F;
                                state_reg <= S_SQ_GO;
                            end
                            asam_pkg::SQ_F:
                            begin
                                sel_reg   <= asam_pkg::SQ_A;
                                state_reg <= S_SQ_GO;
                            end
                            default:
                            begin
                                copy_reg  <= 1'b0;
                                state_reg <= S_DEN;
                            end
                        endcase
                    end
                end
                S_DEN:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (!stat.den_zero && !stat.dot_big)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (!copy_reg)
                    begin
                        copy_reg  <= 1'b1;
                        state_reg <= S_DEN;
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DIV:
                begin
                    if (stat.div_done)
                    begin
                        if (!copy_reg)
                        begin
                            copy_reg  <= 1'b1;
                            state_reg <= S_DEN;
                        end
                        else
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (stat.hit)
                    begin
                        b_reg     <= BW'(lo);
                        state_reg <= S_UPD_RD;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_UPD_RD:
                begin
                    state_reg <= S_UPD_LD;
                end
                S_UPD_LD:
                begin
                    state_reg <= S_UPD_DIV;
                end
                S_UPD_DIV:
                begin
                    if (stat.div_done)
                    begin
                        if (last_b)
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= S_UPD_RD;
                        end
                    end
                end
                S_NEXT:
                begin
                    if (last_ref)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_REF;
                    end
                end
                S_OUT:
                begin
                    if (!stat.out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/asam_checker.sv -----
// checker for the adaptive spectral angle masker: watches the item, result and
// config channels, predicts each pixel's match result and compares it
// depends on asam_pkg
`timescale 1ns / 1ps

module asam_checker #(
    parameter int BANDS = asam_pkg::DEF_BANDS,
    parameter int REFS  = asam_pkg::DEF_REFS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_ready,
    input  asam_pkg::in_item_t              item,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  asam_pkg::out_item_t             result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [asam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asam_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fails,
    output int                              waiting,
    output int                              results_seen
);

    localparam int SW  = asam_pkg::SAMPLE_W;
    localparam int AW  = asam_pkg::ADAPT_W;
    localparam int FW  = asam_pkg::BAND_FIELD_W;
    localparam int CW  = asam_pkg::COUNT_W;
    localparam int MW  = asam_pkg::MASK_W;
    localparam int ASH = asam_pkg::ADAPT_SHIFT;

    logic [SW-1:0]         pix_buf [BANDS];
    logic [FW-1:0]         band_ptr;
    logic [SW-1:0]         fixed_spec [REFS][BANDS];
    logic [AW-1:0]         adapt_spec [REFS][BANDS];
    logic [CW-1:0]         hit_count [REFS];
    asam_pkg::cfg_t        regs;
    asam_pkg::out_item_t   match_q[$];

    initial
    begin
        fails = 0;
        waiting = 0;
        results_seen = 0;
        for (int k = 0; k < REFS; k++)
        begin
            for (int b = 0; b < BANDS; b++)
            begin
                fixed_spec[k][b] = '0;
                adapt_spec[k][b] = '0;
            end
        end
        for (int b = 0; b < BANDS; b++)
            pix_buf[b] = '0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        acc = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= acc + probe)
            begin
                v = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
                acc = acc >> 1;
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // cosine floor(dot * 2^16 / (np * nq)) compared against the threshold
    function automatic bit cos_pass(input longint unsigned dot, input longint unsigned np,
                                    input longint unsigned nq);
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        if (np == 0 || nq == 0)
            return 1'b0;
        den = np * nq;
        if (dot >= den)
            return 1'b1;
        rem = dot;
        quo = 0;
        for (int i = 0; i < asam_pkg::COS_FRAC; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        return quo > longint'(regs.cos_threshold);
    endfunction

    function automatic logic [31:0] classify_pixel();
        int lo;
        int hi;
        int nref;
        logic [31:0] hits;
        longint unsigned psq, np, fsq, asq, df, da, n, p, f, a, tgt;
        lo = regs.first_band;
        hi = regs.last_band_used;
        hits = '0;
        if (hi >= BANDS)
            hi = BANDS - 1;
        nref = (regs.ref_count > REFS) ? REFS : regs.ref_count;
        if (lo > hi || lo >= BANDS)
            return hits;
        psq = 0;
        for (int b = lo; b <= hi; b++)
            psq += longint'(pix_buf[b]) * longint'(pix_buf[b]);
        np = int_sqrt(psq);
        for (int k = 0; k < nref; k++)
        begin
            fsq = 0;
            asq = 0;
            df = 0;
            da = 0;
            for (int b = lo; b <= hi; b++)
            begin
                p = pix_buf[b];
                f = fixed_spec[k][b];
                a = adapt_spec[k][b];
                fsq += f * f;
                asq += a * a;
                df += p * f;
                da += p * a;
            end
            if (cos_pass(df, np, int_sqrt(fsq)) || cos_pass(da, np, int_sqrt(asq)))
            begin
                hits[k] = 1'b1;
                n = (hit_count[k] == '1) ? hit_count[k] : hit_count[k] + 1;
                // running mean of the adaptive copy toward the pixel
                for (int b = lo; b <= hi; b++)
                begin
                    tgt = longint'(pix_buf[b]) << ASH;
                    a = adapt_spec[k][b];
                    if (tgt >= a)
                        a = a + (tgt - a) / n;
                    else
                        a = a - (a - tgt) / n;
                    adapt_spec[k][b] = a[AW-1:0];
                end
                hit_count[k] = n[CW-1:0];
            end
        end
        return hits;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int nfail;
        logic [31:0] hits;
        asam_pkg::out_item_t exp_res;
        nfail = 0;
        if (!rst_n)
        begin
            regs.ref_count = asam_pkg::RST_REF_COUNT;
            regs.first_band = asam_pkg::RST_FIRST_BAND;
            regs.last_band_used = asam_pkg::RST_LAST_BAND_USED;
            regs.cos_threshold = asam_pkg::RST_COS_THRESHOLD;
            band_ptr = '0;
            for (int k = 0; k < REFS; k++)
                hit_count[k] = '0;
            match_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (match_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, result);
                    nfail++;
                end
                else
                begin
                    exp_res = match_q.pop_front();
                    if (result.belongs_mask !== exp_res.belongs_mask)
                    begin
                        $display("%0t: belongs_mask expected %h actual %h", $time,
                                 exp_res.belongs_mask, result.belongs_mask);
                        nfail++;
                    end
                    if (result.belongs_any !== exp_res.belongs_any)
                    begin
                        $display("%0t: belongs_any expected %b actual %b", $time,
                                 exp_res.belongs_any, result.belongs_any);
                        nfail++;
                    end
                    if (result.line_end !== exp_res.line_end)
                    begin
                        $display("%0t: line_end expected %b actual %b", $time,
                                 exp_res.line_end, result.line_end);
                        nfail++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    asam_pkg::CFG_REF_COUNT:      regs.ref_count = cfg_data[3:0];
                    asam_pkg::CFG_FIRST_BAND:     regs.first_band = cfg_data[FW-1:0];
                    asam_pkg::CFG_LAST_BAND_USED: regs.last_band_used = cfg_data[FW-1:0];
                    asam_pkg::CFG_COS_THRESHOLD:  regs.cos_threshold = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                if (item.opcode == asam_pkg::OP_LOAD)
                begin
                    if (item.ref_index < REFS && item.band_index < BANDS)
                    begin
                        fixed_spec[item.ref_index][item.band_index] = item.sample_value;
                        adapt_spec[item.ref_index][item.band_index] =
                            {item.sample_value, {ASH{1'b0}}};
                        hit_count[item.ref_index] = '0;
                    end
                end
                else
                begin
                    pix_buf[band_ptr] = item.sample_value;
                    if (!item.last_band)
                        band_ptr = (band_ptr == BANDS - 1) ? '0 : band_ptr + 1'b1;
                    else
                    begin
                        band_ptr = '0;
                        hits = classify_pixel();
                        exp_res.belongs_mask = hits[MW-1:0];
                        exp_res.belongs_any = (hits != 0);
                        exp_res.line_end = item.last_in_line;
                        match_q.push_back(exp_res);
                    end
                end
            end
        end
        waiting <= match_q.size();
        fails <= fails + nfail;
    end

endmodule

// ----- tb/sv/tb_adaptive_spectral_angle_masker.sv -----
// top of the adaptive spectral angle masker testbench: clock, reset, stimulus
// and verdict; depends on asam_pkg, the block and asam_checker
`timescale 1ns / 1ps

module tb_adaptive_spectral_angle_masker;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            item_valid = 1'b0;
    logic                            item_ready;
    asam_pkg::in_item_t              item = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    asam_pkg::out_item_t             result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [asam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [asam_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int fails;
    int waiting;
    int results_seen;
    int gap_pct = 0;
    int stall_pct = 0;
    int n_beats = 0;
    int n_settings = 0;
    logic [15:0] spec_copy [8][64];

    always #5 clk = ~clk;

    adaptive_spectral_angle_masker dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    asam_checker chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .waiting(waiting), .results_seen(results_seen)
    );

    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin
        #200_000_000;
        $display("tb_adaptive_spectral_angle_masker: FAIL");
        $finish;
    end

    function automatic asam_pkg::in_item_t mk(input logic op, input logic [15:0] s,
                                              input logic [2:0] r, input logic [5:0] b,
                                              input logic lb, input logic eol);
        asam_pkg::in_item_t x;
        x.opcode = op;
        x.sample_value = s;
        x.ref_index = r;
        x.band_index = b;
        x.last_band = lb;
        x.last_in_line = eol;
        return x;
    endfunction

    task automatic send(input asam_pkg::in_item_t x);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        item <= x;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        n_beats++;
    endtask

    task automatic load_band(input int r, input int b, input logic [15:0] v);
        send(mk(asam_pkg::OP_LOAD, v, 3'(r), 6'(b), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1))));
        spec_copy[r][b] = v;
    endtask

    // k >= 0: scaled copy of that reference plus noise; -1: random; -2: full scale
    task automatic send_pixel(input int k, input int len, input int scale, input int noise,
                              input bit eol);
        int v;
        for (int j = 0; j < len; j++)
        begin
            if (k == -1)
                v = $urandom_range(0, 65535);
            else if (k == -2)
                v = 65535;
            else
                v = spec_copy[k][j % 64] * scale / 256 + $urandom_range(0, 2 * noise) - noise;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            send(mk(asam_pkg::OP_PIXEL, 16'(v), 3'($urandom_range(0, 7)),
                    6'($urandom_range(0, 63)), j == len - 1,
                    (j == len - 1) ? eol : 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(input logic [asam_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits above each field carry junk
    task automatic set_regs(input int rc, input int fb, input int lb, input int th);
        drain();
        reg_write(asam_pkg::CFG_REF_COUNT, {12'($urandom_range(0, 4095)), 4'(rc)});
        reg_write(asam_pkg::CFG_FIRST_BAND, {10'($urandom_range(0, 1023)), 6'(fb)});
        reg_write(asam_pkg::CFG_LAST_BAND_USED, {10'($urandom_range(0, 1023)), 6'(lb)});
        reg_write(asam_pkg::CFG_COS_THRESHOLD, 16'(th));
        n_settings++;
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(0, 5))
            0: return 62609;
            1: return 65208;
            2: return 0;
            3: return 65535;
            default: return $urandom_range(50000, 65535);
        endcase
    endfunction

    initial
    begin
        int lo, hi, rc, seg, quota, len, sel;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every reference band; reference 5 is zero in bands 0..3
        for (int r = 0; r < 8; r++)
            for (int b = 0; b < 64; b++)
                load_band(r, b, (r == 5 && b < 4) ? 16'd0 :
                          (r == 7) ? 16'($urandom_range(0, 255)) : 16'($urandom));
        set_regs(8, 0, 63, 62609);
        send_pixel(2, 64, 256, 0, 1'b1);
        send_pixel(-2, 64, 0, 0, 1'b0);
        set_regs(8, 0, 3, 62609);
        send_pixel(0, 4, 0, 0, 1'b1);
        send_pixel(5, 4, 256, 40, 1'b0);
        send_pixel(0, 4, 300, 200, 1'b1);
        set_regs(8, 10, 5, 0);
        send_pixel(1, 1, 256, 0, 1'b1);
        set_regs(0, 0, 3, 0);
        send_pixel(1, 4, 256, 0, 1'b0);
        set_regs(15, 63, 63, 65535);
        send_pixel(1, 64, 256, 0, 1'b1);
        set_regs(15, 0, 7, 65208);
        send_pixel(3, 8, 256, 30, 1'b1);
        send_pixel(3, 70, 256, 0, 1'b0);
        drain();
        for (int i = 4; i < 8; i++)
            reg_write(asam_pkg::CFG_IDX_W'(i), 16'($urandom));

        for (seg = 0; n_beats < 1850; seg++)
        begin
            case ((seg / 2) % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 6; stall_pct = 6; end
            endcase
            sel = $urandom_range(0, 99);
            rc = (sel < 5) ? 0 : (sel < 15) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0)
            begin
                lo = 0;
                hi = 63;
                rc = $urandom_range(1, 2);
            end
            else
            begin
                lo = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 63);
                hi = lo + $urandom_range(0, 7);
                if (hi > 63)
                    hi = 63;
                if ($urandom_range(0, 19) == 0)
                    hi = $urandom_range(0, 63);
            end
            set_regs(rc, lo, hi, pick_threshold());
            quota = n_beats + 70;
            while (n_beats < quota)
            begin
                sel = $urandom_range(0, 99);
                len = hi + 1 + $urandom_range(0, 3);
                if (len > 64)
                    len = 64;
                if (sel < 75)
                    send_pixel($urandom_range(0, 7), len, $urandom_range(192, 320),
                               $urandom_range(0, 600), 1'($urandom_range(0, 1)));
                else if (sel < 85)
                    repeat ($urandom_range(1, 4))
                        load_band($urandom_range(0, 7), $urandom_range(0, 63),
                                  16'($urandom));
                else if (sel < 93)
                    send_pixel(-1, $urandom_range(1, 20), 0, 0, 1'($urandom_range(0, 1)));
                else
                    send_pixel($urandom_range(0, 7), $urandom_range(1, 12), 256,
                               $urandom_range(0, 3000), 1'($urandom_range(0, 1)));
            end
        end
        drain();

        $display("sent %0d beats across %0d register settings, %0d pixel results checked",
                 n_beats, n_settings, results_seen);
        $display("idling mixes: none, sender gaps, receiver stalls, both");
        if (fails == 0)
            $display("tb_adaptive_spectral_angle_masker: PASS");
        else
            $display("tb_adaptive_spectral_angle_masker: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/asam_pkg.sv
rtl/asam_ram.sv
rtl/asam_sqrt.sv
rtl/asam_div.sv
rtl/asam_datapath.sv
rtl/asam_ctrl.sv
rtl/adaptive_spectral_angle_masker.sv
tb/sv/asam_checker.sv
tb/sv/tb_adaptive_spectral_angle_masker.sv
